[design/mafd_pkg.sv]
package mafd_pkg;

   localparam int unsigned CountWidth = 10;

   localparam logic [7:0] CH_START = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [3:0] MIN_CHARS_LESS_ONE = 4'd8;
   localparam logic [3:0] POS_SAT            = 4'd10;

   localparam logic [CountWidth-1:0] MAX_BYTES_RESET = 10'd255;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
   localparam logic [2:0] STATUS_BAD_START = 3'd2;
   localparam logic [2:0] STATUS_BAD_END   = 3'd3;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd4;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0]            data_byte;
      logic                  byte_valid;
      logic                  frame_done;
      logic [2:0]            status;
      logic                  lrc_ok;
      logic [CountWidth-1:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic    has_result;
      rsp_type rsp;
   } step_type;

   // bit 4: valid digit, bits 3..0: value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

[design/modbus_ascii_frame_decoder_core.sv]
// A result appears on rsp_valid in the cycle after its character beat is taken.
// Throughput: one character per cycle while no result waits on rsp_ready; the output
// register frees as its beat leaves. Characters with no result leave nothing behind.
// Reset (synchronous): frame state cleared, output empty, max_bytes back to 255.
module modbus_ascii_frame_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mafd_pkg::req_type                req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mafd_pkg::rsp_type                rsp_item,
   input  logic                             csr_wr_en,
   input  logic [mafd_pkg::CountWidth-1:0]  csr_wr_data
);

   logic [mafd_pkg::CountWidth-1:0] max_bytes_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   mafd_pkg::rsp_type               rsp_ff, rsp_in;
   mafd_pkg::step_type              step;
   logic                            accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   mafd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .req       (req_item),
      .max_bytes (max_bytes_ff),
      .step      (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = step.has_result;
         rsp_in       = step.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= mafd_pkg::MAX_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_bytes_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_rsp_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.byte_valid || rsp_ff.frame_done))
      else $error("empty result beat");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.frame_done) |-> (rsp_ff.status == mafd_pkg::STATUS_OK &&
                                                !rsp_ff.lrc_ok))
      else $error("status reported mid frame");

   a_byte_within_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.byte_valid) |-> (rsp_ff.byte_count != '0))
      else $error("byte emitted with zero count");

endmodule

[design/mafd_frame.sv]
module mafd_frame (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  mafd_pkg::req_type                req,
   input  logic [mafd_pkg::CountWidth-1:0]  max_bytes,
   output mafd_pkg::step_type               step
);

   logic [3:0]                      char_position_ff, char_position_in;
   logic                            position_odd_ff, position_odd_in;
   logic [7:0]                      previous_char_ff, previous_char_in;
   logic [4:0]                      high_nibble_ff, high_nibble_in;
   logic [7:0]                      held_byte_ff, held_byte_in;
   logic [1:0]                      held_flags_ff, held_flags_in;
   logic                            start_ok_ff, start_ok_in;
   logic                            hex_error_ff, hex_error_in;
   logic [mafd_pkg::CountWidth-1:0] decoded_count_ff, decoded_count_in;
   logic [7:0]                      lrc_sum_ff, lrc_sum_in;

   logic [4:0] digit;
   logic       emit;
   logic [2:0] status;

   assign digit = mafd_pkg::hex_digit(req.ch);

   always_comb begin
      char_position_in = char_position_ff;
      position_odd_in  = position_odd_ff;
      previous_char_in = previous_char_ff;
      high_nibble_in   = high_nibble_ff;
      held_byte_in     = held_byte_ff;
      held_flags_in    = held_flags_ff;
      start_ok_in      = start_ok_ff;
      hex_error_in     = hex_error_ff;
      decoded_count_in = decoded_count_ff;
      lrc_sum_in       = lrc_sum_ff;
      emit             = 1'b0;
      status           = mafd_pkg::STATUS_OK;

      if (char_position_ff == 4'd0) begin
         start_ok_in = (req.ch == mafd_pkg::CH_START);
      end else if (position_odd_ff) begin
         high_nibble_in = digit;
      end else begin
         if (held_flags_ff[0] && start_ok_ff && !hex_error_ff &&
             decoded_count_ff < max_bytes) begin
            if (held_flags_ff[1]) begin
               emit             = 1'b1;
               decoded_count_in = decoded_count_ff +
                                  {{(mafd_pkg::CountWidth-1){1'b0}}, 1'b1};
               lrc_sum_in       = lrc_sum_ff + held_byte_ff;
            end else begin
               hex_error_in = 1'b1;
            end
         end
         held_byte_in  = {high_nibble_ff[3:0], digit[3:0]};
         held_flags_in = {high_nibble_ff[4] & digit[4], 1'b1};
      end

      priority if (char_position_ff < mafd_pkg::MIN_CHARS_LESS_ONE) begin
         status = mafd_pkg::STATUS_TOO_SHORT;
      end else if (!start_ok_in) begin
         status = mafd_pkg::STATUS_BAD_START;
      end else if (previous_char_ff != mafd_pkg::CH_CR || req.ch != mafd_pkg::CH_LF) begin
         status = mafd_pkg::STATUS_BAD_END;
      end else if (hex_error_in) begin
         status = mafd_pkg::STATUS_BAD_HEX;
      end else begin
         status = mafd_pkg::STATUS_OK;
      end

      step.has_result     = emit | req.end_of_frame;
      step.rsp.data_byte  = emit ? held_byte_ff : 8'd0;
      step.rsp.byte_valid = emit;
      step.rsp.frame_done = req.end_of_frame;
      step.rsp.status     = req.end_of_frame ? status : mafd_pkg::STATUS_OK;
      step.rsp.lrc_ok     = req.end_of_frame && decoded_count_in != '0 && lrc_sum_in == 8'd0;
      step.rsp.byte_count = decoded_count_in;

      if (req.end_of_frame) begin
         char_position_in = 4'd0;
         position_odd_in  = 1'b0;
         previous_char_in = 8'd0;
         high_nibble_in   = 5'd0;
         held_byte_in     = 8'd0;
         held_flags_in    = 2'd0;
         start_ok_in      = 1'b0;
         hex_error_in     = 1'b0;
         decoded_count_in = '0;
         lrc_sum_in       = 8'd0;
      end else begin
         if (char_position_ff < mafd_pkg::POS_SAT) begin
            char_position_in = char_position_ff + 4'd1;
         end
         position_odd_in  = ~position_odd_ff;
         previous_char_in = req.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff <= 4'd0;
         position_odd_ff  <= 1'b0;
         previous_char_ff <= 8'd0;
         high_nibble_ff   <= 5'd0;
         held_byte_ff     <= 8'd0;
         held_flags_ff    <= 2'd0;
         start_ok_ff      <= 1'b0;
         hex_error_ff     <= 1'b0;
         decoded_count_ff <= '0;
         lrc_sum_ff       <= 8'd0;
      end else if (step_en) begin
         char_position_ff <= char_position_in;
         position_odd_ff  <= position_odd_in;
         previous_char_ff <= previous_char_in;
         high_nibble_ff   <= high_nibble_in;
         held_byte_ff     <= held_byte_in;
         held_flags_ff    <= held_flags_in;
         start_ok_ff      <= start_ok_in;
         hex_error_ff     <= hex_error_in;
         decoded_count_ff <= decoded_count_in;
         lrc_sum_ff       <= lrc_sum_in;
      end
   end

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      char_position_ff <= mafd_pkg::POS_SAT)
      else $error("char position past saturation");

   a_odd_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      (char_position_ff == 4'd0) |-> !position_odd_ff)
      else $error("odd flag set at frame start");

   a_no_emit_after_hex_err: assert property (@(posedge clock) disable iff (reset)
      hex_error_ff |-> !emit)
      else $error("byte emitted after hex error");

endmodule
